// File: src/motor_speed_filter_turn_tracker_defines.svh
// Assertion macros shared by the speed filter and turn tracker RTL.
`ifndef MOTOR_SPEED_FILTER_TURN_TRACKER_DEFINES_SVH
`define MOTOR_SPEED_FILTER_TURN_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check, reset disables the check.
`define MSF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication check, reset disables the check.
`define MSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define MSF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/msf_pkg.sv
// Types, constants and rounding helper for the speed filter and turn tracker.
`default_nettype none
package msf_pkg;

  // Default parameter values
  localparam int ENC_BITS_DEF  = 13;
  localparam int FRAC_BITS_DEF = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Field widths fixed by the interface
  localparam int VEL_W   = 16;
  localparam int COEF_W  = 19;
  localparam int SSCL_W  = 24;
  localparam int ASCL_W  = 32;
  localparam int FULL_W  = 7;
  localparam int CNT_W   = 8;
  localparam int DATA_W  = 32;
  localparam int EXTO_W  = 21;

  // Rounding shifts
  localparam int FILT_SHIFT  = 16;
  localparam int SPEED_SHIFT = 24;
  localparam int ANGLE_BASE  = 32;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV1  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV2  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_INPUT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_BOUND  = CFG_IDX_W'(5);

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_PREV1_RST = COEF_W'(113096);
  localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = -COEF_W'(49542);
  localparam logic signed [COEF_W-1:0] COEF_INPUT_RST = COEF_W'(1982);
  localparam logic [SSCL_W-1:0]        SPEED_SCALE_RST = SSCL_W'(48803);
  localparam logic [ASCL_W-1:0]        ANGLE_SCALE_RST = ASCL_W'(91505);
  localparam logic [FULL_W-1:0]        WRAP_BOUND_RST  = FULL_W'(18);

  // Saturation bounds for 32-bit signed results
  localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) << 31) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) << 31);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_P1,
    S_P2,
    S_IN,
    S_SUM,
    S_Y,
    S_SPD,
    S_ANG,
    S_DONE
  } fsm_state_t;

  // Round half toward plus infinity by sh bits, then saturate to 32 bits signed
  function automatic logic signed [DATA_W-1:0] rnd_sat32(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              sh
  );
    logic signed [PROD_W-1:0] b;
    logic signed [PROD_W-1:0] r;
    b = v + (PROD_W'(1) << (sh - 1));
    r = b >>> sh;
    if (r > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return r[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/motor_speed_filter_turn_tracker.sv
// Speed low-pass filter and multi-turn position tracker for one motor.
// The result is registered after the sequencer runs states P1, P2, IN, SUM, Y, SPD, ANG
// and DONE; a new sample is taken only once the last result is loaded. One shared
// 33x25 signed multiplier runs five products per sample under the sequencer.
// Reset (synchronous, active high) clears filter history and turn counter and
// loads the default coefficients, scales and wrap bound.
`default_nettype none
`include "motor_speed_filter_turn_tracker_defines.svh"
module motor_speed_filter_turn_tracker #(
  parameter int ENC_BITS  = msf_pkg::ENC_BITS_DEF,
  parameter int FRAC_BITS = msf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [msf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [msf_pkg::CFG_DAT_W-1:0]         cfg_data,
  // sample input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [msf_pkg::VEL_W-1:0]      velocity_rpm,
  input  wire logic [ENC_BITS-1:0]                   position,
  input  wire logic [ENC_BITS-1:0]                   last_position,
  // result output channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [msf_pkg::DATA_W-1:0]          filtered_speed,
  output logic signed [msf_pkg::CNT_W-1:0]           turn_count,
  output logic signed [msf_pkg::EXTO_W-1:0]          extended_position,
  output logic signed [msf_pkg::DATA_W-1:0]          angle
);

  localparam int EXT_W  = ENC_BITS + msf_pkg::CNT_W;
  localparam int DIFF_W = ENC_BITS + 1;
  localparam int STEP_W = msf_pkg::CNT_W + 1;
  localparam logic signed [DIFF_W-1:0] HALF = DIFF_W'(1) << (ENC_BITS - 1);

  // configuration registers
  logic signed [msf_pkg::COEF_W-1:0] coef_prev1;
  logic signed [msf_pkg::COEF_W-1:0] coef_prev2;
  logic signed [msf_pkg::COEF_W-1:0] coef_input;
  logic [msf_pkg::SSCL_W-1:0]        speed_scale;
  logic [msf_pkg::ASCL_W-1:0]        angle_scale;
  logic [msf_pkg::FULL_W-1:0]        wrap_bound;

  // filter and counter state
  logic signed [msf_pkg::DATA_W-1:0] filter_prev1;
  logic signed [msf_pkg::DATA_W-1:0] filter_prev2;
  logic signed [msf_pkg::CNT_W-1:0]  turn_counter;

  // sample and datapath registers
  logic signed [msf_pkg::VEL_W-1:0]  vel_reg;
  logic [ENC_BITS-1:0]               pos_reg;
  logic [ENC_BITS-1:0]               last_reg;
  logic signed [msf_pkg::PROD_W-1:0] prod;
  logic signed [msf_pkg::PROD_W-1:0] acc;
  logic signed [msf_pkg::DATA_W-1:0] spd_reg;

  msf_pkg::fsm_state_t state;
  msf_pkg::fsm_state_t state_next;

  logic signed [msf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [msf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [msf_pkg::PROD_W-1:0]  mul_out;
  logic                               prod_en;
  logic                               in_xfer;
  logic                               out_load;

  logic signed [EXT_W-1:0]            ext;
  logic signed [DIFF_W-1:0]           diff;
  logic [msf_pkg::FULL_W-1:0]         full_eff;
  logic signed [STEP_W-1:0]           full_s;
  logic signed [STEP_W-1:0]           cnt_step;
  logic signed [STEP_W-1:0]           cnt_wrap;
  logic signed [msf_pkg::DATA_W-1:0]  y_new;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state == msf_pkg::S_DONE) && (!out_valid || !out_stall);

  // Extended position is the counter stacked above the encoder count
  assign ext = $signed({turn_counter, pos_reg});

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_prev1  <= msf_pkg::COEF_PREV1_RST;
      coef_prev2  <= msf_pkg::COEF_PREV2_RST;
      coef_input  <= msf_pkg::COEF_INPUT_RST;
      speed_scale <= msf_pkg::SPEED_SCALE_RST;
      angle_scale <= msf_pkg::ANGLE_SCALE_RST;
      wrap_bound  <= msf_pkg::WRAP_BOUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msf_pkg::CFG_COEF_PREV1:  coef_prev1  <= $signed(cfg_data[msf_pkg::COEF_W-1:0]);
        msf_pkg::CFG_COEF_PREV2:  coef_prev2  <= $signed(cfg_data[msf_pkg::COEF_W-1:0]);
        msf_pkg::CFG_COEF_INPUT:  coef_input  <= $signed(cfg_data[msf_pkg::COEF_W-1:0]);
        msf_pkg::CFG_SPEED_SCALE: speed_scale <= cfg_data[msf_pkg::SSCL_W-1:0];
        msf_pkg::CFG_ANGLE_SCALE: angle_scale <= cfg_data[msf_pkg::ASCL_W-1:0];
        msf_pkg::CFG_WRAP_BOUND:  wrap_bound  <= cfg_data[msf_pkg::FULL_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, input stall and multiplier operand select
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    prod_en    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      msf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = msf_pkg::S_P1;
        end
      end
      msf_pkg::S_P1: begin
        prod_en    = 1'b1;
        mul_a      = msf_pkg::MUL_A_W'(filter_prev1);
        mul_b      = msf_pkg::MUL_B_W'(coef_prev1);
        state_next = msf_pkg::S_P2;
      end
      msf_pkg::S_P2: begin
        prod_en    = 1'b1;
        mul_a      = msf_pkg::MUL_A_W'(filter_prev2);
        mul_b      = msf_pkg::MUL_B_W'(coef_prev2);
        state_next = msf_pkg::S_IN;
      end
      msf_pkg::S_IN: begin
        prod_en    = 1'b1;
        mul_a      = msf_pkg::MUL_A_W'(vel_reg);
        mul_b      = msf_pkg::MUL_B_W'(coef_input);
        state_next = msf_pkg::S_SUM;
      end
      msf_pkg::S_SUM: begin
        state_next = msf_pkg::S_Y;
      end
      msf_pkg::S_Y: begin
        state_next = msf_pkg::S_SPD;
      end
      msf_pkg::S_SPD: begin
        prod_en    = 1'b1;
        mul_a      = msf_pkg::MUL_A_W'(filter_prev1);
        mul_b      = $signed({1'b0, speed_scale});
        state_next = msf_pkg::S_ANG;
      end
      msf_pkg::S_ANG: begin
        prod_en    = 1'b1;
        mul_a      = $signed({1'b0, angle_scale});
        mul_b      = msf_pkg::MUL_B_W'(ext);
        state_next = msf_pkg::S_DONE;
      end
      msf_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = msf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = msf_pkg::S_IDLE;
      end
    endcase
  end

  // Shared multiplier
  assign mul_out = mul_a * mul_b;

  // Turn counter step and wrap
  always_comb begin
    diff     = $signed({1'b0, pos_reg}) - $signed({1'b0, last_reg});
    full_eff = (wrap_bound == '0) ? msf_pkg::FULL_W'(1) : wrap_bound;
    full_s   = $signed({2'b00, full_eff});
    cnt_step = STEP_W'(turn_counter);
    if (diff > HALF) begin
      cnt_step = cnt_step - STEP_W'(1);
    end else if (diff < -HALF) begin
      cnt_step = cnt_step + STEP_W'(1);
    end
    cnt_wrap = cnt_step;
    if (cnt_step >= full_s) begin
      cnt_wrap = -full_s;
    end else if (cnt_step <= -(full_s + STEP_W'(1))) begin
      cnt_wrap = full_s - STEP_W'(1);
    end
  end

  // New filter output from the accumulated sum
  assign y_new = msf_pkg::rnd_sat32(acc, msf_pkg::FILT_SHIFT);

  // Capture the sample on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vel_reg  <= velocity_rpm;
      pos_reg  <= position;
      last_reg <= last_position;
    end
  end

  // Product register, filter accumulator and speed result register
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= mul_out;
    end
    if (state == msf_pkg::S_P2) begin
      acc <= prod;
    end else if (state == msf_pkg::S_IN) begin
      acc <= acc + prod;
    end else if (state == msf_pkg::S_SUM) begin
      acc <= acc + (prod <<< FRAC_BITS);
    end
    if (state == msf_pkg::S_ANG) begin
      spd_reg <= msf_pkg::rnd_sat32(prod, msf_pkg::SPEED_SHIFT);
    end
  end

  // Advance filter history and turn counter
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_prev1 <= '0;
      filter_prev2 <= '0;
      turn_counter <= '0;
    end else if (state == msf_pkg::S_Y) begin
      filter_prev2 <= filter_prev1;
      filter_prev1 <= y_new;
      turn_counter <= cnt_wrap[msf_pkg::CNT_W-1:0];
    end
  end

  // Output register: load when the slot is free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_speed    <= spd_reg;
      turn_count        <= turn_counter;
      extended_position <= msf_pkg::EXTO_W'(ext);
      angle             <= msf_pkg::rnd_sat32(prod, msf_pkg::ANGLE_BASE - FRAC_BITS);
    end
  end

  // Checks
  `MSF_ASSERT_NEXT(a_xfer_starts_item, clk, rst, in_xfer, state == msf_pkg::S_P1)
  `MSF_ASSERT_NEXT(a_history_shifts, clk, rst, state == msf_pkg::S_Y, filter_prev2 == $past(filter_prev1))
  `MSF_ASSERT_IMPL(a_counter_in_range, clk, rst, state == msf_pkg::S_SPD, (turn_counter >= -$signed({2'b00, $past(full_eff)})) && (turn_counter < $signed({2'b00, $past(full_eff)})))
  `MSF_ASSERT_NEXT(a_result_held, clk, rst, (state == msf_pkg::S_DONE) && out_valid && out_stall, state == msf_pkg::S_DONE)

endmodule
`default_nettype wire

// File: bench/tb_motor_speed_filter_turn_tracker.sv
// Testbench for the motor speed filter and multi-turn position tracker.
`default_nettype none
module tb_motor_speed_filter_turn_tracker;

  localparam int ENC_RANGE     = 1 << msf_pkg::ENC_BITS_DEF;
  localparam int HALF_RANGE    = ENC_RANGE / 2;
  localparam int ANGLE_SHIFT   = msf_pkg::ANGLE_BASE - msf_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam logic [msf_pkg::CFG_IDX_W-1:0] CFG_INDEX_SPARE = msf_pkg::CFG_IDX_W'(6);
  localparam logic [msf_pkg::CFG_IDX_W-1:0] CFG_INDEX_TOP   = msf_pkg::CFG_IDX_W'(255);

  typedef struct packed {
    logic signed [msf_pkg::VEL_W-1:0]     vel;
    logic [msf_pkg::ENC_BITS_DEF-1:0]     pos;
    logic [msf_pkg::ENC_BITS_DEF-1:0]     last;
  } sample_t;

  typedef struct packed {
    logic signed [msf_pkg::DATA_W-1:0]    speed;
    logic signed [msf_pkg::CNT_W-1:0]     turns;
    logic signed [msf_pkg::EXTO_W-1:0]    ext_pos;
    logic signed [msf_pkg::DATA_W-1:0]    ang;
  } feedback_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [msf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [msf_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [msf_pkg::VEL_W-1:0] velocity_rpm = '0;
  logic [msf_pkg::ENC_BITS_DEF-1:0] position = '0;
  logic [msf_pkg::ENC_BITS_DEF-1:0] last_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [msf_pkg::DATA_W-1:0] filtered_speed;
  logic signed [msf_pkg::CNT_W-1:0] turn_count;
  logic signed [msf_pkg::EXTO_W-1:0] extended_position;
  logic signed [msf_pkg::DATA_W-1:0] angle;

  motor_speed_filter_turn_tracker dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .velocity_rpm      (velocity_rpm),
    .position          (position),
    .last_position     (last_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_speed    (filtered_speed),
    .turn_count        (turn_count),
    .extended_position (extended_position),
    .angle             (angle)
  );

  // Predictor copy of the registers and state
  logic signed [msf_pkg::COEF_W-1:0] k_prev1, k_prev2, k_input;
  logic [msf_pkg::SSCL_W-1:0]        spd_scale;
  logic [msf_pkg::ASCL_W-1:0]        ang_scale;
  logic [msf_pkg::FULL_W-1:0]        wrap_count;
  logic signed [msf_pkg::DATA_W-1:0] y_prev1, y_prev2;
  int                                turns;

  sample_t   sample_pending_q[$];
  feedback_t feedback_expected_q[$];
  sample_t   drv_item;
  sample_t   seen_item;
  feedback_t want;
  logic      in_fire = 1'b0;
  int        error_count = 0;
  int unsigned cycle_count = 0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        enc_now = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int        stall_phase = 0;
  int        stall_period = 2;
  int        stall_duty = 1;

  // Round half up by sh bits, then clamp to 32 bits signed
  function automatic logic signed [msf_pkg::DATA_W-1:0] rnd_sat(input longint v, input int sh);
    longint q;
    q = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[msf_pkg::DATA_W-1:0];
  endfunction

  // Advance the filter and turn counter by one sample
  function automatic feedback_t filter_and_track(input sample_t s);
    feedback_t r;
    longint acc;
    logic signed [msf_pkg::DATA_W-1:0] y;
    int diff;
    int limit;
    int ext;
    acc = longint'(k_prev1) * longint'(y_prev1)
        + longint'(k_prev2) * longint'(y_prev2)
        + longint'(k_input) * (longint'(s.vel) <<< msf_pkg::FRAC_BITS_DEF);
    y = rnd_sat(acc, msf_pkg::FILT_SHIFT);
    y_prev2 = y_prev1;
    y_prev1 = y;
    r.speed = rnd_sat(longint'(y) * longint'(spd_scale), msf_pkg::SPEED_SHIFT);

    diff = int'(s.pos) - int'(s.last);
    limit = (wrap_count == 0) ? 1 : int'(wrap_count);
    if (diff > HALF_RANGE) turns--;
    else if (diff < -HALF_RANGE) turns++;
    if (turns >= limit) turns = -limit;
    else if (turns <= -(limit + 1)) turns = limit - 1;

    ext = turns * ENC_RANGE + int'(s.pos);
    r.turns = turns[msf_pkg::CNT_W-1:0];
    r.ext_pos = ext[msf_pkg::EXTO_W-1:0];
    r.ang = rnd_sat(longint'(ext) * longint'(ang_scale), ANGLE_SHIFT);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Sample side: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_pending_q.size() > 0) begin
        drv_item = sample_pending_q.pop_front();
        velocity_rpm <= drv_item.vel;
        position <= drv_item.pos;
        last_position <= drv_item.last;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 9))
            0: gap_left = $urandom_range(13, 30);
            1, 2: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(0, 3);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: a new random stall mode, period and duty each time the phase runs out
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_period = $urandom_range(2, 9);
      stall_duty = $urandom_range(1, stall_period - 1);
      stall_phase = 64;
    end
    stall_phase--;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 40);
      STALL_PERIODIC: out_stall <= ((stall_phase % stall_period) < stall_duty);
      default:        out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Track register writes, predict on sample transfers, check result transfers
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      k_prev1 = msf_pkg::COEF_PREV1_RST;
      k_prev2 = msf_pkg::COEF_PREV2_RST;
      k_input = msf_pkg::COEF_INPUT_RST;
      spd_scale = msf_pkg::SPEED_SCALE_RST;
      ang_scale = msf_pkg::ANGLE_SCALE_RST;
      wrap_count = msf_pkg::WRAP_BOUND_RST;
      y_prev1 = '0;
      y_prev2 = '0;
      turns = 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msf_pkg::CFG_COEF_PREV1:  k_prev1 = cfg_data[msf_pkg::COEF_W-1:0];
          msf_pkg::CFG_COEF_PREV2:  k_prev2 = cfg_data[msf_pkg::COEF_W-1:0];
          msf_pkg::CFG_COEF_INPUT:  k_input = cfg_data[msf_pkg::COEF_W-1:0];
          msf_pkg::CFG_SPEED_SCALE: spd_scale = cfg_data[msf_pkg::SSCL_W-1:0];
          msf_pkg::CFG_ANGLE_SCALE: ang_scale = cfg_data[msf_pkg::ASCL_W-1:0];
          msf_pkg::CFG_WRAP_BOUND:  wrap_count = cfg_data[msf_pkg::FULL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (feedback_expected_q.size() == 0) begin
          $display("%0t: result transfer with no sample pending: speed %0d turns %0d pos %0d angle %0d",
                   $time, filtered_speed, turn_count, extended_position, angle);
          error_count++;
        end else begin
          want = feedback_expected_q.pop_front();
          if (filtered_speed !== want.speed) begin
            $display("%0t: filtered_speed expected %0d got %0d", $time, want.speed, filtered_speed);
            error_count++;
          end
          if (turn_count !== want.turns) begin
            $display("%0t: turn_count expected %0d got %0d", $time, want.turns, turn_count);
            error_count++;
          end
          if (extended_position !== want.ext_pos) begin
            $display("%0t: extended_position expected %0d got %0d",
                     $time, want.ext_pos, extended_position);
            error_count++;
          end
          if (angle !== want.ang) begin
            $display("%0t: angle expected %0d got %0d", $time, want.ang, angle);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen_item.vel = velocity_rpm;
        seen_item.pos = position;
        seen_item.last = last_position;
        feedback_expected_q.push_back(filter_and_track(seen_item));
      end
    end
  end

  task automatic push_sample(input int vel, input int pos, input int last);
    sample_t s;
    s.vel = msf_pkg::VEL_W'(vel);
    s.pos = msf_pkg::ENC_BITS_DEF'(pos);
    s.last = msf_pkg::ENC_BITS_DEF'(last);
    sample_pending_q.push_back(s);
  endtask

  // Random velocity: mostly moderate, some full range, a few rail values
  function automatic logic signed [msf_pkg::VEL_W-1:0] random_velocity();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2, 3, 4: return msf_pkg::VEL_W'($urandom());
      default: return msf_pkg::VEL_W'(int'($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  // Queue continuous rotation runs with occasional noise and broken history
  task automatic add_rotation(input int n);
    sample_t s;
    int run_left;
    int mag;
    int step;
    run_left = 0;
    step = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: mag = $urandom_range(0, 40);
          1: mag = $urandom_range(100, 2000);
          2: mag = $urandom_range(2500, 4095);
          default: mag = $urandom_range(4090, 4100);
        endcase
        step = $urandom_range(0, 1) ? mag : -mag;
      end
      run_left--;
      s.last = enc_now[msf_pkg::ENC_BITS_DEF-1:0];
      enc_now = (enc_now + step + ENC_RANGE) % ENC_RANGE;
      s.pos = enc_now[msf_pkg::ENC_BITS_DEF-1:0];
      case ($urandom_range(0, 19))
        0, 1: begin
          s.pos = msf_pkg::ENC_BITS_DEF'($urandom());
          s.last = msf_pkg::ENC_BITS_DEF'($urandom());
        end
        2: s.last = msf_pkg::ENC_BITS_DEF'($urandom());
        default: ;
      endcase
      s.vel = random_velocity();
      sample_pending_q.push_back(s);
    end
  endtask

  // Queue a forward wrap on every sample so the counter keeps stepping up
  task automatic add_spin(input int n);
    for (int i = 0; i < n; i++) begin
      enc_now = $urandom_range(0, 2000);
      push_sample(int'(random_velocity()), enc_now, $urandom_range(6200, ENC_RANGE - 1));
    end
  endtask

  task automatic write_reg(input logic [msf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msf_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every sample is sent and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_pending_q.size() != 0 || in_valid || feedback_expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    wait (cycle_count == RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes and the half-range thresholds
    push_sample(0, 0, 0);
    push_sample(32767, 8191, 8191);
    push_sample(-32768, 0, 8191);
    push_sample(-1, 8191, 0);
    push_sample(1, 4096, 0);
    push_sample(32767, 4097, 0);
    push_sample(32767, 0, 4096);
    push_sample(-32768, 0, 4097);
    for (int i = 0; i < 5; i++) push_sample(-32768, 0, 8000);
    wait_idle();

    // Zero wrap bound acts as one; counter left outside range gets pulled back
    write_reg(msf_pkg::CFG_WRAP_BOUND, '0);
    push_sample(100, 10, 10);
    push_sample(200, 0, 8191);
    push_sample(300, 0, 8191);
    push_sample(-300, 8191, 0);
    push_sample(0, 8191, 0);
    push_sample(0, 4000, 100);
    wait_idle();

    // Random coefficients and scales, widest bound, counter driven up to its top and wrapped to the bottom
    write_reg(msf_pkg::CFG_COEF_PREV1, $urandom());
    write_reg(msf_pkg::CFG_COEF_PREV2, $urandom());
    write_reg(msf_pkg::CFG_COEF_INPUT, $urandom());
    write_reg(msf_pkg::CFG_SPEED_SCALE, $urandom());
    write_reg(msf_pkg::CFG_ANGLE_SCALE, $urandom());
    write_reg(msf_pkg::CFG_WRAP_BOUND, msf_pkg::CFG_DAT_W'(127));
    add_spin(130);
    wait_idle();

    // Upper extremes, unstable filter driven into both rails, writes to unused indexes
    write_reg(msf_pkg::CFG_COEF_PREV1, msf_pkg::CFG_DAT_W'(262143));
    write_reg(msf_pkg::CFG_COEF_PREV2, msf_pkg::CFG_DAT_W'(-262144));
    write_reg(msf_pkg::CFG_COEF_INPUT, msf_pkg::CFG_DAT_W'(262143));
    write_reg(msf_pkg::CFG_SPEED_SCALE, msf_pkg::CFG_DAT_W'(24'hffffff));
    write_reg(msf_pkg::CFG_ANGLE_SCALE, 32'hffffffff);
    write_reg(msf_pkg::CFG_WRAP_BOUND, msf_pkg::CFG_DAT_W'(1));
    write_reg(CFG_INDEX_SPARE, $urandom());
    write_reg(CFG_INDEX_TOP, $urandom());
    add_rotation(120);
    wait_idle();

    // Lower extremes
    write_reg(msf_pkg::CFG_COEF_PREV1, msf_pkg::CFG_DAT_W'(-262144));
    write_reg(msf_pkg::CFG_COEF_PREV2, msf_pkg::CFG_DAT_W'(262143));
    write_reg(msf_pkg::CFG_COEF_INPUT, msf_pkg::CFG_DAT_W'(-262144));
    write_reg(msf_pkg::CFG_SPEED_SCALE, '0);
    write_reg(msf_pkg::CFG_ANGLE_SCALE, '0);
    write_reg(msf_pkg::CFG_WRAP_BOUND, msf_pkg::CFG_DAT_W'(127));
    add_rotation(80);
    wait_idle();

    // Stable low-pass with random scales and a small bound
    write_reg(msf_pkg::CFG_COEF_PREV1, msf_pkg::CFG_DAT_W'(msf_pkg::COEF_PREV1_RST));
    write_reg(msf_pkg::CFG_COEF_PREV2, msf_pkg::CFG_DAT_W'(msf_pkg::COEF_PREV2_RST));
    write_reg(msf_pkg::CFG_COEF_INPUT, msf_pkg::CFG_DAT_W'(msf_pkg::COEF_INPUT_RST));
    write_reg(msf_pkg::CFG_SPEED_SCALE, $urandom());
    write_reg(msf_pkg::CFG_ANGLE_SCALE, $urandom());
    write_reg(msf_pkg::CFG_WRAP_BOUND, msf_pkg::CFG_DAT_W'($urandom_range(1, 40)));
    add_rotation(160);
    wait_idle();

    // Fully random register words
    write_reg(msf_pkg::CFG_COEF_PREV1, $urandom());
    write_reg(msf_pkg::CFG_COEF_PREV2, $urandom());
    write_reg(msf_pkg::CFG_COEF_INPUT, $urandom());
    write_reg(msf_pkg::CFG_SPEED_SCALE, $urandom());
    write_reg(msf_pkg::CFG_ANGLE_SCALE, $urandom());
    write_reg(msf_pkg::CFG_WRAP_BOUND, $urandom());
    add_rotation(160);
    wait_idle();

    if (error_count == 0 && feedback_expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: motor_speed_filter_turn_tracker.f
+incdir+src
src/msf_pkg.sv
src/motor_speed_filter_turn_tracker.sv
bench/tb_motor_speed_filter_turn_tracker.sv
